// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under an active-low reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/rosl_pkg.sv
// Shared types and constants of the ray/box slab test.
// Used by the front, back and top-level modules; depends on nothing.
package rosl_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int REACH_W     = 31;
    localparam int HIT_TDATA_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADING_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADING_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADING_Z = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_REACH     = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DOT,
        ST_CHECK,
        ST_DLOAD,
        ST_DIV,
        ST_DSTORE,
        ST_UPDATE,
        ST_FINISH
    } back_state_t;

    // Queue head status from front to back
    typedef struct packed {
        logic valid;
        logic last;
    } q_stat_t;

endpackage

// File: sv/rosl_front.sv
// Front end: accepts slab transactions, forms centre minus origin exactly,
// and holds them in a two-entry queue for the back end. Uses rosl_pkg.
module rosl_front import rosl_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [8*WORD_WIDTH-1:0]       s_tdata,
    input  logic                          s_tlast,
    input  logic [2:0][WORD_WIDTH-1:0]    origin,
    output q_stat_t                       q_stat,
    input  logic                          q_ready,
    output logic [2:0][WORD_WIDTH-1:0]    q_axis,
    output logic [2:0][WORD_WIDTH:0]      q_delta,
    output logic [WORD_WIDTH-1:0]         q_lo,
    output logic [WORD_WIDTH-1:0]         q_hi
);

    localparam int W = WORD_WIDTH;

    logic [2:0][W-1:0] in_axis;
    logic [2:0][W-1:0] in_center;
    logic [2:0][W:0]   in_delta;

    logic [1:0][2:0][W-1:0] axis_mem;
    logic [1:0][2:0][W:0]   delta_mem;
    logic [1:0][W-1:0]      lo_mem;
    logic [1:0][W-1:0]      hi_mem;
    logic [1:0]             last_mem;

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_axis[i]   = s_tdata[i*W +: W];
            in_center[i] = s_tdata[(3+i)*W +: W];
            in_delta[i]  = {in_center[i][W-1], in_center[i]} - {origin[i][W-1], origin[i]};
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_stat.valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            axis_mem[wr_ptr_reg]  <= in_axis;
            delta_mem[wr_ptr_reg] <= in_delta;
            lo_mem[wr_ptr_reg]    <= s_tdata[6*W +: W];
            hi_mem[wr_ptr_reg]    <= s_tdata[7*W +: W];
            last_mem[wr_ptr_reg]  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign q_stat.valid = (count_reg != 2'd0);
    assign q_stat.last  = last_mem[rd_ptr_reg];
    assign q_axis       = axis_mem[rd_ptr_reg];
    assign q_delta      = delta_mem[rd_ptr_reg];
    assign q_lo         = lo_mem[rd_ptr_reg];
    assign q_hi         = hi_mem[rd_ptr_reg];

endmodule

// File: sv/rosl_back.sv
// Back end: bit-serial dot products, restoring divisions and the near/far
// interval update for one slab at a time, plus the result register. Uses rosl_pkg.
module rosl_back import rosl_pkg::*; #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  q_stat_t                       q_stat,
    output logic                          q_ready,
    input  logic [2:0][WORD_WIDTH-1:0]    q_axis,
    input  logic [2:0][WORD_WIDTH:0]      q_delta,
    input  logic [WORD_WIDTH-1:0]         q_lo,
    input  logic [WORD_WIDTH-1:0]         q_hi,
    input  logic [2:0][WORD_WIDTH-1:0]    heading,
    input  logic [REACH_W-1:0]            reach,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit
);

    localparam int W     = WORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int ACC_W = 2*W + 2;
    localparam int NB    = W + 1 + F;
    localparam int CNT_W = $clog2(NB + 1);
    localparam int EPS_I = ((1 << FRAC_BITS) + 500) / 1000;

    localparam logic [W-1:0]        EPS    = W'(EPS_I);
    localparam logic signed [W-1:0] WMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [63:0]         WMAX64 = (64'd1 << (W-1)) - 64'd1;
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(WMAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(WMIN);
    localparam logic [NB-1:0]       LIM_POS = NB'(WMAX64);

    back_state_t state_reg, state_next;

    logic [2:0][W-1:0]       axis_reg, axis_next;
    logic [2:0][W:0]         delta_reg, delta_next;
    logic signed [W-1:0]     lo_reg, lo_next, hi_reg, hi_next;
    logic                    last_reg, last_next;
    logic [2:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [ACC_W-1:0]        mcand_reg, mcand_next;
    logic [W:0]              mplier_reg, mplier_next;
    logic                    mneg_reg, mneg_next;
    logic signed [W-1:0]     e_reg, e_next, f_reg, f_next;
    logic [W-1:0]            den_reg, den_next;
    logic [NB-1:0]           numer_reg, numer_next;
    logic [W:0]              rem_reg, rem_next;
    logic [NB-1:0]           quot_reg, quot_next;
    logic                    qneg_reg, qneg_next;
    logic                    dsel_reg, dsel_next;
    logic signed [W-1:0]     t1_reg, t1_next, t2_reg, t2_next;
    logic signed [W-1:0]     near_reg, near_next, far_reg, far_next;
    logic                    missed_reg, missed_next;
    logic                    open_reg, open_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    hit_reg, hit_next;

    // Combinational helpers
    logic [W:0]              op_a, op_b, mag_a, mag_b;
    logic                    eff_missed;
    logic [63:0]             reach64;
    logic signed [W-1:0]     reach_sat;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [W-1:0]     dot_val;
    logic [W-1:0]            mag_f;
    logic                    f_big;
    logic signed [W:0]       num;
    logic [W:0]              num_mag;
    logic [W:0]              r2;
    logic                    ge;
    logic [NB-1:0]           lim, q_sat;
    logic signed [W-1:0]     t_val, t_lo, t_hi, far_n, near_n;
    logic                    mul_done, div_done, slot_free;

    // Operand selection for the six products
    always_comb
    begin
        case (idx_reg)
            3'd0: begin op_a = {axis_reg[0][W-1], axis_reg[0]}; op_b = delta_reg[0]; end
            3'd1: begin op_a = {axis_reg[1][W-1], axis_reg[1]}; op_b = delta_reg[1]; end
            3'd2: begin op_a = {axis_reg[2][W-1], axis_reg[2]}; op_b = delta_reg[2]; end
            3'd3: begin op_a = {heading[0][W-1], heading[0]}; op_b = {axis_reg[0][W-1], axis_reg[0]}; end
            3'd4: begin op_a = {heading[1][W-1], heading[1]}; op_b = {axis_reg[1][W-1], axis_reg[1]}; end
            3'd5: begin op_a = {heading[2][W-1], heading[2]}; op_b = {axis_reg[2][W-1], axis_reg[2]}; end
            default: begin op_a = '0; op_b = '0; end
        endcase
        mag_a = op_a[W] ? (~op_a + 1'b1) : op_a;
        mag_b = op_b[W] ? (~op_b + 1'b1) : op_b;
    end

    always_comb
    begin
        eff_missed = open_reg ? missed_reg : 1'b0;
        reach64    = 64'(reach);
        reach_sat  = (reach64 > WMAX64) ? WMAX : reach64[W-1:0];

        // Floor shift then saturate to the word
        acc_sh = $signed(acc_reg) >>> F;
        if (acc_sh > ACC_MAX)
            dot_val = WMAX;
        else if (acc_sh < ACC_MIN)
            dot_val = WMIN;
        else
            dot_val = acc_sh[W-1:0];

        mag_f = f_reg[W-1] ? (~f_reg + 1'b1) : f_reg;
        f_big = (mag_f > EPS);

        num     = {e_reg[W-1], e_reg} + (dsel_reg ? {hi_reg[W-1], hi_reg} : {lo_reg[W-1], lo_reg});
        num_mag = num[W] ? (~num + 1'b1) : num;

        r2 = {rem_reg[W-1:0], numer_reg[NB-1]};
        ge = (r2 >= {1'b0, den_reg});

        lim   = qneg_reg ? (LIM_POS + 1'b1) : LIM_POS;
        q_sat = (quot_reg > lim) ? lim : quot_reg;
        t_val = qneg_reg ? (~q_sat[W-1:0] + 1'b1) : q_sat[W-1:0];

        t_lo   = (t1_reg > t2_reg) ? t2_reg : t1_reg;
        t_hi   = (t1_reg > t2_reg) ? t1_reg : t2_reg;
        far_n  = (t_hi < far_reg) ? t_hi : far_reg;
        near_n = (t_lo > near_reg) ? t_lo : near_reg;

        mul_done  = (cnt_reg == CNT_W'(W));
        div_done  = (cnt_reg == CNT_W'(NB - 1));
        slot_free = !out_valid_reg || out_ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_stat.valid)
                    state_next = eff_missed ? ST_FINISH : ST_LOAD;
            ST_LOAD:
                state_next = ST_MUL;
            ST_MUL:
                if (mul_done)
                    state_next = (idx_reg == 3'd2 || idx_reg == 3'd5) ? ST_DOT : ST_LOAD;
            ST_DOT:
                state_next = (idx_reg == 3'd3) ? ST_LOAD : ST_CHECK;
            ST_CHECK:
                state_next = f_big ? ST_DLOAD : ST_FINISH;
            ST_DLOAD:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_DSTORE;
            ST_DSTORE:
                state_next = dsel_reg ? ST_UPDATE : ST_DLOAD;
            ST_UPDATE:
                state_next = ST_FINISH;
            ST_FINISH:
                if (!last_reg || slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        axis_next      = axis_reg;
        delta_next     = delta_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        mneg_next      = mneg_reg;
        e_next         = e_reg;
        f_next         = f_reg;
        den_next       = den_reg;
        numer_next     = numer_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        qneg_next      = qneg_reg;
        dsel_next      = dsel_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        near_next      = near_reg;
        far_next       = far_reg;
        missed_next    = missed_reg;
        open_next      = open_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_ready        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_stat.valid)
                begin
                    axis_next  = q_axis;
                    delta_next = q_delta;
                    lo_next    = q_lo;
                    hi_next    = q_hi;
                    last_next  = q_stat.last;
                    idx_next   = 3'd0;
                    acc_next   = '0;
                    if (!open_reg)
                    begin
                        near_next   = '0;
                        far_next    = reach_sat;
                        missed_next = 1'b0;
                        open_next   = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                mcand_next  = ACC_W'(mag_a);
                mplier_next = mag_b;
                mneg_next   = op_a[W] ^ op_b[W];
                cnt_next    = '0;
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                    acc_next = mneg_reg ? (acc_reg - mcand_reg) : (acc_reg + mcand_reg);
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (mul_done)
                    idx_next = idx_reg + 3'd1;
            end
            ST_DOT:
            begin
                if (idx_reg == 3'd3)
                    e_next = dot_val;
                else
                    f_next = dot_val;
                acc_next = '0;
            end
            ST_CHECK:
            begin
                den_next  = mag_f;
                dsel_next = 1'b0;
                if (!f_big)
                    missed_next = (lo_reg > e_reg) || (hi_reg < e_reg);
            end
            ST_DLOAD:
            begin
                numer_next = {num_mag, {F{1'b0}}};
                rem_next   = '0;
                quot_next  = '0;
                qneg_next  = num[W] ^ f_reg[W-1];
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                rem_next   = ge ? (r2 - {1'b0, den_reg}) : r2;
                quot_next  = {quot_reg[NB-2:0], ge};
                numer_next = numer_reg << 1;
                cnt_next   = cnt_reg + 1'b1;
            end
            ST_DSTORE:
            begin
                if (dsel_reg)
                    t2_next = t_val;
                else
                    t1_next = t_val;
                dsel_next = 1'b1;
            end
            ST_UPDATE:
            begin
                far_next    = far_n;
                near_next   = near_n;
                missed_next = (far_n < near_n);
            end
            ST_FINISH:
            begin
                if (last_reg && slot_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = !missed_reg;
                    open_next      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        axis_reg   <= axis_next;
        delta_reg  <= delta_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        mneg_reg   <= mneg_next;
        e_reg      <= e_next;
        f_reg      <= f_next;
        den_reg    <= den_next;
        numer_reg  <= numer_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        qneg_reg   <= qneg_next;
        dsel_reg   <= dsel_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        hit_reg    <= hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            near_reg      <= '0;
            far_reg       <= '0;
            missed_reg    <= 1'b0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            near_reg      <= near_next;
            far_reg       <= far_next;
            missed_reg    <= missed_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

endmodule

// File: sv/ray_obb_slab_test.sv
// Top level of the ray/oriented-box slab test: configuration registers,
// front queue and back end. Uses rosl_pkg, rosl_front and rosl_back.
//
// In the back end each slab transaction runs six bit-serial products and, when
// the ray is not parallel to the slab, two restoring divisions; a parallel slab
// skips the divisions, and a slab of a box already missed skips both. The front
// queue holds two slabs, so the source can run ahead of the back end, and the
// result register lets the back end carry on while a hit/miss result waits.
// Configuration writes are never stalled and must only be issued while idle.
module ray_obb_slab_test import rosl_pkg::*; #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int CFG_WIDTH = (WORD_WIDTH > REACH_W) ? WORD_WIDTH : REACH_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // axis_x, axis_y, axis_z, center_x, center_y, center_z, slab_lo, slab_hi
    input  logic [8*WORD_WIDTH-1:0]     s_tdata,
    input  logic                        s_tlast,   // final_slab
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // hit, zero padded
    output logic [HIT_TDATA_W-1:0]      m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_WIDTH-1:0]        cfg_data
);

    localparam int W = WORD_WIDTH;

    logic [2:0][W-1:0]       origin_reg;
    logic [2:0][W-1:0]       heading_reg;
    logic [REACH_W-1:0]      reach_reg;

    q_stat_t                 q_stat;
    logic                    q_ready;
    logic [2:0][W-1:0]       q_axis;
    logic [2:0][W:0]         q_delta;
    logic [W-1:0]            q_lo, q_hi;
    logic                    hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg  <= '0;
            heading_reg <= '0;
            reach_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_X:  origin_reg[0]  <= cfg_data[W-1:0];
                REG_ORIGIN_Y:  origin_reg[1]  <= cfg_data[W-1:0];
                REG_ORIGIN_Z:  origin_reg[2]  <= cfg_data[W-1:0];
                REG_HEADING_X: heading_reg[0] <= cfg_data[W-1:0];
                REG_HEADING_Y: heading_reg[1] <= cfg_data[W-1:0];
                REG_HEADING_Z: heading_reg[2] <= cfg_data[W-1:0];
                REG_REACH:     reach_reg      <= cfg_data[REACH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    rosl_front #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .origin   (origin_reg),
        .q_stat   (q_stat),
        .q_ready  (q_ready),
        .q_axis   (q_axis),
        .q_delta  (q_delta),
        .q_lo     (q_lo),
        .q_hi     (q_hi)
    );

    rosl_back #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_ready   (q_ready),
        .q_axis    (q_axis),
        .q_delta   (q_delta),
        .q_lo      (q_lo),
        .q_hi      (q_hi),
        .heading   (heading_reg),
        .reach     (reach_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hit       (hit)
    );

    assign m_tdata = {{(HIT_TDATA_W-1){1'b0}}, hit};

endmodule

// File: sv/rosl_checker.sv
// Port-level checks for the slab test, bound to the top level.
// Depends on assert_macros.svh and the top level's port list.
`include "assert_macros.svh"

module rosl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // Hold a stalled result transaction
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // Only the hit bit may be set
    `ASSERT_IMPL(a_out_pad, clk, rst_n, m_tvalid, m_tdata[7:1] == 7'd0)
    // Register writes never stall
    `ASSERT_IMPL(a_cfg_taken, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind ray_obb_slab_test rosl_checker u_rosl_checker (.*);
